// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define CRC8FD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define CRC8FD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication that also holds across reset.
`define CRC8FD_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: rtl/core/crc8fd_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 framed command deframer package
// Shared types, constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package crc8fd_pkg;

    localparam int unsigned ByteW        = 8;
    localparam logic [7:0]  CrcPoly      = 8'h07;
    localparam logic [7:0]  CrcInit      = 8'h00;
    localparam logic [7:0]  StartByteRst = 8'hAA;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_PHI  = 3'd2,
        PH_PLO  = 3'd3,
        PH_CRC  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] command;
        logic [ByteW-1:0] param_high;
        logic [ByteW-1:0] param_low;
    } t_frame;

    // CRC-8, MSB first, one whole byte per call
    function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
        logic [ByteW-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < ByteW; i++) begin
            if (v[ByteW-1]) begin
                v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                v = {v[ByteW-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: rtl/core/crc8fd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Phase tracking, running CRC and held frame bytes; one byte per step.
// ----------------------------------------------------------------------------
module crc8fd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [crc8fd_pkg::ByteW-1:0]  i_byte,
    input  logic [crc8fd_pkg::ByteW-1:0]  i_start_byte,
    output logic                          o_hit,
    output crc8fd_pkg::t_frame            o_frame
);

    crc8fd_pkg::t_phase             r_phase;
    crc8fd_pkg::t_phase             n_phase;
    logic [crc8fd_pkg::ByteW-1:0]   r_crc;
    logic [crc8fd_pkg::ByteW-1:0]   n_crc;
    logic [crc8fd_pkg::ByteW-1:0]   r_command;
    logic [crc8fd_pkg::ByteW-1:0]   n_command;
    logic [crc8fd_pkg::ByteW-1:0]   r_param_high;
    logic [crc8fd_pkg::ByteW-1:0]   n_param_high;
    logic [crc8fd_pkg::ByteW-1:0]   r_param_low;
    logic [crc8fd_pkg::ByteW-1:0]   n_param_low;
    logic                           w_crc_match;
    logic                           w_is_start;
    logic [crc8fd_pkg::ByteW-1:0]   w_crc_upd;

    assign w_crc_match = (i_byte == r_crc);
    assign w_is_start  = (i_byte == i_start_byte);
    assign w_crc_upd   = crc8fd_pkg::crc8_step(r_crc, i_byte);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                crc8fd_pkg::PH_CMD: n_phase = crc8fd_pkg::PH_PHI;
                crc8fd_pkg::PH_PHI: n_phase = crc8fd_pkg::PH_PLO;
                crc8fd_pkg::PH_PLO: n_phase = crc8fd_pkg::PH_CRC;
                crc8fd_pkg::PH_CRC: begin
                    if (w_crc_match) begin
                        n_phase = crc8fd_pkg::PH_HUNT;
                    end else if (w_is_start) begin
                        n_phase = crc8fd_pkg::PH_CMD;
                    end else begin
                        n_phase = crc8fd_pkg::PH_HUNT;
                    end
                end
                default: begin
                    n_phase = w_is_start ? crc8fd_pkg::PH_CMD : crc8fd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // CRC, held bytes and frame hit
    always_comb begin
        n_crc        = r_crc;
        n_command    = r_command;
        n_param_high = r_param_high;
        n_param_low  = r_param_low;
        o_hit        = 1'b0;
        if (i_step) begin
            unique case (r_phase)
                crc8fd_pkg::PH_CMD: begin
                    n_command = i_byte;
                    n_crc     = w_crc_upd;
                end
                crc8fd_pkg::PH_PHI: begin
                    n_param_high = i_byte;
                    n_crc        = w_crc_upd;
                end
                crc8fd_pkg::PH_PLO: begin
                    n_param_low = i_byte;
                    n_crc       = w_crc_upd;
                end
                crc8fd_pkg::PH_CRC: begin
                    if (w_crc_match) begin
                        o_hit = 1'b1;
                    end else if (w_is_start) begin
                        // restart the frame on a start byte seen in place of the CRC
                        n_crc = crc8fd_pkg::crc8_step(crc8fd_pkg::CrcInit, i_byte);
                    end
                end
                default: begin
                    if (w_is_start) begin
                        n_crc = crc8fd_pkg::crc8_step(crc8fd_pkg::CrcInit, i_byte);
                    end
                end
            endcase
        end
    end

    assign o_frame = '{command: r_command, param_high: r_param_high, param_low: r_param_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= crc8fd_pkg::PH_HUNT;
            r_crc   <= crc8fd_pkg::CrcInit;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_command    <= n_command;
        r_param_high <= n_param_high;
        r_param_low  <= n_param_low;
    end

endmodule

// File: rtl/core/crc8_framed_command_deframer_core.sv
// ----------------------------------------------------------------------------
// CRC-8 framed command deframer
// Finds start/command/param-high/param-low/CRC frames in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Receive channel: i_rx_valid / o_rx_ready with i_rx_byte, one byte per
//   request. Command channel: o_cmd_valid / i_cmd_ready with o_command,
//   o_param_high and o_param_low, one request per frame whose CRC byte
//   matches (CRC-8, poly 0x07, init 0, MSB first, over the first four bytes).
//   i_cfg_we / i_cfg_wdata write the start-of-frame byte; write only while
//   no bytes are in flight.
//   A matching CRC byte sets o_cmd_valid through the command register.
//   Throughput: one byte per cycle unless the command side stalls, set by the
//   input register feeding the parser and the single-entry command register.
//   Reset (synchronous, active low) returns the parser to hunting, empties
//   the input and command registers and sets the start byte to 0xAA.
//   When the receiver stalls, the pending command is held and the parser
//   stops stepping; one more byte may wait in the input register, after
//   which o_rx_ready stays low until the command request is taken.
// ----------------------------------------------------------------------------
module crc8_framed_command_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [crc8fd_pkg::ByteW-1:0]  i_cfg_wdata,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [crc8fd_pkg::ByteW-1:0]  i_rx_byte,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output logic [crc8fd_pkg::ByteW-1:0]  o_command,
    output logic [crc8fd_pkg::ByteW-1:0]  o_param_high,
    output logic [crc8fd_pkg::ByteW-1:0]  o_param_low
);

    logic                           r_in_valid;
    logic                           n_in_valid;
    logic [crc8fd_pkg::ByteW-1:0]   r_in_byte;
    logic [crc8fd_pkg::ByteW-1:0]   r_start_byte;
    logic                           r_out_valid;
    logic                           n_out_valid;
    crc8fd_pkg::t_frame             r_out;
    logic                           w_rx_take;
    logic                           w_advance;
    logic                           w_hit;
    crc8fd_pkg::t_frame             w_frame;

    // advance the held byte only when the command register can take a result
    assign w_advance  = r_in_valid && (!r_out_valid || i_cmd_ready);
    assign o_rx_ready = !r_in_valid || w_advance;
    assign w_rx_take  = i_rx_valid && o_rx_ready;

    crc8fd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .o_hit        (w_hit),
        .o_frame      (w_frame)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_rx_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_cmd_ready;
        if (w_hit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_start_byte <= crc8fd_pkg::StartByteRst;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_hit) begin
            r_out <= w_frame;
        end
    end

    assign o_cmd_valid  = r_out_valid;
    assign o_command    = r_out.command;
    assign o_param_high = r_out.param_high;
    assign o_param_low  = r_out.param_low;

endmodule

// File: rtl/core/crc8fd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8fd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rx_ready,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic [crc8fd_pkg::ByteW-1:0]  i_command,
    input logic [crc8fd_pkg::ByteW-1:0]  i_param_high,
    input logic [crc8fd_pkg::ByteW-1:0]  i_param_low
);

    // a stalled command request stays up
    `CRC8FD_ASSERT_NXT(a_cmd_hold, i_clk, i_rst_n, i_cmd_valid && !i_cmd_ready, i_cmd_valid)

    // and keeps its payload
    `CRC8FD_ASSERT_NXT(a_cmd_stable, i_clk, i_rst_n, i_cmd_valid && !i_cmd_ready, $stable(i_command) && $stable(i_param_high) && $stable(i_param_low))

    // the receive side only stalls behind a blocked command
    `CRC8FD_ASSERT_IMP(a_rx_stall, i_clk, i_rst_n, !i_rx_ready, i_cmd_valid && !i_cmd_ready)

    // reset drops any pending command and opens the receive side
    `CRC8FD_ASSERT_NXT_ANY(a_rst_clear, i_clk, !i_rst_n, !i_cmd_valid && i_rx_ready)

endmodule

bind crc8_framed_command_deframer_core crc8fd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_ready   (o_rx_ready),
    .i_cmd_valid  (o_cmd_valid),
    .i_cmd_ready  (i_cmd_ready),
    .i_command    (o_command),
    .i_param_high (o_param_high),
    .i_param_low  (o_param_low)
);

// File: bench/tb_crc8_framed_command_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-8 framed command deframer testbench
// Streams good, corrupt, truncated and noisy frames into the deframer under
// several start byte settings, with random gaps on the byte side and random
// stalls on the command side. Each decoded command is predicted from the byte
// stream and compared field by field with the request the block returns.
// ----------------------------------------------------------------------------
module tb_crc8_framed_command_deframer_core;
    import crc8fd_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_BYTES    = 500;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [ByteW-1:0] i_cfg_wdata;
    logic             i_rx_valid;
    logic             o_rx_ready;
    logic [ByteW-1:0] i_rx_byte;
    logic             o_cmd_valid;
    logic             i_cmd_ready;
    logic [ByteW-1:0] o_command;
    logic [ByteW-1:0] o_param_high;
    logic [ByteW-1:0] o_param_low;

    // parser mirror
    t_phase           exp_phase;
    logic [ByteW-1:0] exp_crc;
    logic [ByteW-1:0] exp_cmd;
    logic [ByteW-1:0] exp_phi;
    logic [ByteW-1:0] exp_plo;
    logic [ByteW-1:0] exp_start;

    t_frame frames_due[$];

    bit src_idle_on;
    bit sink_idle_on;
    bit sink_hold;

    int bytes_sent;
    int frames_checked;
    int cfg_writes;
    int rx_stall_cycles;
    int mismatch_count;

    crc8_framed_command_deframer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_cmd_valid  (o_cmd_valid),
        .i_cmd_ready  (i_cmd_ready),
        .o_command    (o_command),
        .o_param_high (o_param_high),
        .o_param_low  (o_param_low)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Bit-serial CRC-8, MSB first: feed each data bit into the top of the register
    function automatic logic [ByteW-1:0] crc8_fold(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
        logic [ByteW-1:0] r;
        logic             fb;
        r = crc;
        for (int i = ByteW - 1; i >= 0; i--) begin
            fb = r[ByteW-1] ^ data[i];
            r  = {r[ByteW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
        end
        return r;
    endfunction

    function automatic logic [ByteW-1:0] frame_crc(input logic [ByteW-1:0] cmd,
                                                   input logic [ByteW-1:0] ph,
                                                   input logic [ByteW-1:0] pl);
        return crc8_fold(crc8_fold(crc8_fold(crc8_fold(CrcInit, exp_start), cmd), ph), pl);
    endfunction

    // Advance the parser mirror by one byte; returns 1 when a command is due
    function automatic bit parse_rx_byte(input logic [ByteW-1:0] b, output t_frame f);
        bit produced;
        produced = 1'b0;
        f        = '0;
        case (exp_phase)
            PH_CMD: begin
                exp_cmd   = b;
                exp_crc   = crc8_fold(exp_crc, b);
                exp_phase = PH_PHI;
            end
            PH_PHI: begin
                exp_phi   = b;
                exp_crc   = crc8_fold(exp_crc, b);
                exp_phase = PH_PLO;
            end
            PH_PLO: begin
                exp_plo   = b;
                exp_crc   = crc8_fold(exp_crc, b);
                exp_phase = PH_CRC;
            end
            PH_CRC: begin
                if (b == exp_crc) begin
                    exp_phase    = PH_HUNT;
                    f.command    = exp_cmd;
                    f.param_high = exp_phi;
                    f.param_low  = exp_plo;
                    produced     = 1'b1;
                end else if (b == exp_start) begin
                    exp_crc   = crc8_fold(CrcInit, exp_start);
                    exp_phase = PH_CMD;
                end else begin
                    exp_phase = PH_HUNT;
                end
            end
            default: begin
                if (b == exp_start) begin
                    exp_crc   = crc8_fold(CrcInit, exp_start);
                    exp_phase = PH_CMD;
                end else begin
                    exp_phase = PH_HUNT;
                end
            end
        endcase
        return produced;
    endfunction

    // Payload byte, now and then equal to the start byte
    function automatic logic [ByteW-1:0] pick_byte();
        return ($urandom_range(0, 7) == 0) ? exp_start : ByteW'($urandom);
    endfunction

    task automatic flag_mismatch(input string what, input t_frame want, input t_frame got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t %s: expected cmd %02h hi %02h lo %02h, actual cmd %02h hi %02h lo %02h",
                     $time, what, want.command, want.param_high, want.param_low,
                     got.command, got.param_high, got.param_low);
        end
    endtask

    // Called at a rising edge; returns at the edge where the request is taken
    task automatic send_rx_byte(input logic [ByteW-1:0] b);
        int     gap;
        t_frame f;
        gap = src_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(negedge i_clk); while (o_rx_ready !== 1'b1);
        @(posedge i_clk);
        bytes_sent++;
        if (parse_rx_byte(b, f)) begin
            frames_due.push_back(f);
        end
    endtask

    task automatic send_frame(input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] ph,
                              input logic [ByteW-1:0] pl, input bit corrupt);
        logic [ByteW-1:0] crc;
        crc = frame_crc(cmd, ph, pl);
        if (corrupt) begin
            crc ^= ByteW'($urandom_range(1, 255));
        end
        send_rx_byte(exp_start);
        send_rx_byte(cmd);
        send_rx_byte(ph);
        send_rx_byte(pl);
        send_rx_byte(crc);
    endtask

    // Let the pipeline empty before touching the register
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [ByteW-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        exp_start = v;
        cfg_writes++;
    endtask

    task automatic test_directed();
        logic [ByteW-1:0] bad;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_rx_byte(8'h00);
        send_frame(8'h00, 8'h00, 8'h00, 1'b0);
        // start byte as frame content: no resync inside a frame
        send_frame(exp_start, exp_start, exp_start, 1'b0);
        // wrong CRC equal to the start byte opens the next frame
        send_rx_byte(exp_start);
        send_rx_byte(8'h12);
        send_rx_byte(8'h34);
        send_rx_byte(8'h56);
        send_rx_byte(exp_start);
        send_rx_byte(8'hFF);
        send_rx_byte(8'hFF);
        send_rx_byte(8'hFF);
        send_rx_byte(frame_crc(8'hFF, 8'hFF, 8'hFF));
        // wrong CRC of any other value drops back to hunting
        bad = frame_crc(8'h01, 8'h02, 8'h03) ^ 8'h01;
        if (bad == exp_start) begin
            bad ^= 8'h03;
        end
        send_rx_byte(exp_start);
        send_rx_byte(8'h01);
        send_rx_byte(8'h02);
        send_rx_byte(8'h03);
        send_rx_byte(bad);
        drain();
    endtask

    task automatic test_start_byte_extremes();
        logic [ByteW-1:0] settings[3];
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = ByteW'($urandom);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (settings[i]) begin
            write_start_byte(settings[i]);
            send_frame(pick_byte(), pick_byte(), pick_byte(), 1'b0);
            send_frame(pick_byte(), pick_byte(), pick_byte(), 1'b1);
            send_rx_byte(settings[i] ^ 8'h01);
            send_rx_byte(settings[i] ^ 8'h80);
            send_frame(exp_start, exp_start, exp_start, 1'b0);
            drain();
        end
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int target;
        int kind;
        for (int stretch = 0; stretch < 4; stretch++) begin
            write_start_byte(ByteW'($urandom));
            src_idle_on  = (stretch == 0) || (stretch == 2);
            sink_idle_on = (stretch == 0) || (stretch == 3);
            target = bytes_sent + n_bytes / 4;
            while (bytes_sent < target) begin
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    send_frame(pick_byte(), pick_byte(), pick_byte(), 1'b0);
                end else if (kind < 75) begin
                    send_frame(pick_byte(), pick_byte(), pick_byte(), 1'b1);
                end else if (kind < 85) begin
                    // truncated frame: whatever follows lands inside it
                    send_rx_byte(exp_start);
                    repeat ($urandom_range(0, 3)) send_rx_byte(pick_byte());
                end else begin
                    repeat ($urandom_range(1, 4)) send_rx_byte(ByteW'($urandom));
                end
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        sink_hold   <= 1'b1;
        fork
            begin
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++) begin
            send_frame(pick_byte(), pick_byte(), pick_byte(), 1'b0);
        end
        drain();
    endtask

    // Command side: random stalls per request, plus the long hold-off
    initial begin : cmd_sink
        int gap;
        i_cmd_ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = sink_idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_cmd_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            while (sink_hold) begin
                i_cmd_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_cmd_ready <= 1'b1;
            do @(negedge i_clk); while (o_cmd_valid !== 1'b1);
            @(posedge i_clk);
        end
    end

    // Sample between edges; a request seen here is taken at the next rising edge
    always @(negedge i_clk) begin
        t_frame got;
        t_frame want;
        if (i_rst_n === 1'b1) begin
            if (i_rx_valid === 1'b1 && o_rx_ready !== 1'b1) begin
                rx_stall_cycles++;
            end
            if (o_cmd_valid === 1'b1 && i_cmd_ready === 1'b1) begin
                got.command    = o_command;
                got.param_high = o_param_high;
                got.param_low  = o_param_low;
                if (frames_due.size() == 0) begin
                    flag_mismatch("unexpected command", '0, got);
                end else begin
                    want = frames_due.pop_front();
                    frames_checked++;
                    if (got.command !== want.command || got.param_high !== want.param_high ||
                        got.param_low !== want.param_low) begin
                        flag_mismatch("command mismatch", want, got);
                    end
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d commands outstanding", frames_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        sink_hold   = 1'b0;
        exp_phase   = PH_HUNT;
        exp_crc     = '0;
        exp_cmd     = '0;
        exp_phi     = '0;
        exp_plo     = '0;
        exp_start   = StartByteRst;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_start_byte_extremes();
        test_backpressure();
        test_random_traffic(RANDOM_BYTES);

        i_rx_valid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (frames_due.size() != 0) begin
            flag_mismatch("missing command", frames_due.pop_front(), '0);
        end

        $display("sent %0d bytes over %0d start byte settings, checked %0d commands",
                 bytes_sent, cfg_writes, frames_checked);
        $display("byte input held off for %0d cycles by command back-pressure",
                 rx_stall_cycles);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
